### hdl/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// Shared codes, field widths and defaults of the cursor list engine.
// ----------------------------------------------------------------------------
package cle_pkg;

    // Default sizing of the list storage.
    localparam int CAPACITY_DEF  = 256;
    localparam int DATA_BITS_DEF = 32;

    // Field widths of the stream payloads.
    localparam int ACTION_W  = 4;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 9;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 120;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_CLEAR     = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_FRONT     = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_BACK      = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_PREV      = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_NEXT      = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_PREPEND   = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_APPEND    = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_BEFORE    = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_AFTER     = 4'd8;
    localparam logic [ACTION_W-1:0] ACT_DELFRONT  = 4'd9;
    localparam logic [ACTION_W-1:0] ACT_DELBACK   = 4'd10;
    localparam logic [ACTION_W-1:0] ACT_DELCURSOR = 4'd11;
    localparam logic [ACTION_W-1:0] ACT_QUERY     = 4'd12;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOCURS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

endpackage

### hdl/cle_ram.sv
// ----------------------------------------------------------------------------
// cle_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module cle_ram
    import cle_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int WIDTH = DATA_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/cursor_list_engine.sv
// ----------------------------------------------------------------------------
// cursor_list_engine
// Bounded doubly linked list with one cursor, held in link memories with a
// free-slot stack. Each transaction performs one action and reports the list.
// ----------------------------------------------------------------------------
// Channel   Direction  Fields (lowest bit first)
// s_axis    in         tuser: action[3:0]; tdata: value[31:0]
// m_axis    out        tdata: status, count, cursor_position, cursor_defined,
//                      front_value, back_value, cursor_value
//
// Each item runs through four states before the next is accepted: the
// accepting state reads links and free stack, S_LINK reads the element those
// links name, S_EXEC captures it and writes the new slot, S_COMMIT commits.
// The chain of two dependent memory reads sets these steps.
// Synchronous active-low reset empties the list; memories need no clearing.
// The commit cycle waits while the previous result is not yet taken.
// ----------------------------------------------------------------------------
module cursor_list_engine
    import cle_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // value[31:0]
    input  logic [ACTION_W-1:0]   i_s_axis_tuser,  // action[3:0]
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // status[1:0], count[10:2], cursor_position[19:11], cursor_defined[20],
    // front_value[52:21], back_value[84:53], cursor_value[116:85], zeros
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = SW + 1;
    localparam logic [LW-1:0] NIL = LW'(CAPACITY);
    localparam logic [LW-1:0] ONE = LW'(1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LINK   = 2'd1;
    localparam logic [1:0] S_EXEC   = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    function automatic logic [SW-1:0] f_sl(input logic [LW-1:0] s);
        return (s < NIL) ? s[SW-1:0] : '0;
    endfunction

    logic [1:0]           r_state;
    logic [ACTION_W-1:0]  r_act;
    logic [DATA_BITS-1:0] r_val;
    logic [LW-1:0]        r_nx, r_pv, r_tgt;
    logic [SW-1:0]        r_slot;
    logic [DATA_BITS-1:0] r_eval;
    logic [LW-1:0]        r_head, r_tail, r_cur, r_cidx, r_count, r_fsd, r_fresh;
    logic [DATA_BITS-1:0] r_hval, r_tval, r_cval;
    logic                 r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;

    logic [LW-1:0]        n_head, n_tail, n_cur, n_cidx, n_count, n_fsd, n_fresh;
    logic [DATA_BITS-1:0] n_hval, n_tval, n_cval;

    // Memory ports.
    logic                 nx_we, pv_we, el_we, sk_we;
    logic [SW-1:0]        nx_wa, pv_wa, el_wa, sk_wa, lk_ra, el_ra, sk_ra;
    logic [LW-1:0]        nx_wd, pv_wd, nx_rd, pv_rd;
    logic [DATA_BITS-1:0] el_rd;
    logic [SW-1:0]        sk_wd, sk_rd;

    cle_ram #(.DEPTH(CAPACITY), .WIDTH(LW)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_raddr(lk_ra), .o_rdata(nx_rd));
    cle_ram #(.DEPTH(CAPACITY), .WIDTH(LW)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_raddr(lk_ra), .o_rdata(pv_rd));
    cle_ram #(.DEPTH(CAPACITY), .WIDTH(DATA_BITS)) u_elem (
        .i_clk(i_clk), .i_we(el_we), .i_waddr(el_wa), .i_wdata(r_val),
        .i_raddr(el_ra), .o_rdata(el_rd));
    cle_ram #(.DEPTH(CAPACITY), .WIDTH(SW)) u_stack (
        .i_clk(i_clk), .i_we(sk_we), .i_waddr(sk_wa), .i_wdata(sk_wd),
        .i_raddr(sk_ra), .o_rdata(sk_rd));

    // List conditions and the status of the pending action.
    logic c_empty, c_cdef, c_full, c_ok, c_go;
    logic [STATUS_W-1:0] c_st;
    assign c_empty = (r_count == '0);
    assign c_cdef  = (r_cur != NIL);
    assign c_full  = (r_count >= NIL);

    always_comb begin
        c_st = ST_OK;
        case (r_act)
            ACT_FRONT, ACT_BACK, ACT_DELFRONT, ACT_DELBACK: begin
                if (c_empty) c_st = ST_EMPTY;
            end
            ACT_PREV, ACT_NEXT, ACT_DELCURSOR: begin
                if (c_empty) c_st = ST_EMPTY;
                else if (!c_cdef) c_st = ST_NOCURS;
            end
            ACT_PREPEND, ACT_APPEND: begin
                if (c_full) c_st = ST_FULL;
            end
            ACT_BEFORE, ACT_AFTER: begin
                if (c_empty) c_st = ST_EMPTY;
                else if (!c_cdef) c_st = ST_NOCURS;
                else if (c_full) c_st = ST_FULL;
            end
            default: c_st = ST_OK;
        endcase
    end
    assign c_ok = (c_st == ST_OK);
    assign c_go = (r_state == S_COMMIT) && (!r_ovalid || i_m_axis_tready);

    // Kind of insert and the slot to delete.
    logic is_ins, is_del, k_first, k_front, k_back, k_midb, k_mida;
    logic [LW-1:0] c_s, c_x;
    assign is_ins  = (r_act inside {ACT_PREPEND, ACT_APPEND, ACT_BEFORE, ACT_AFTER});
    assign is_del  = (r_act inside {ACT_DELFRONT, ACT_DELBACK, ACT_DELCURSOR});
    assign k_first = is_ins && c_empty;
    assign k_front = ((r_act == ACT_PREPEND) && !c_empty) ||
                     ((r_act == ACT_BEFORE) && (r_cur == r_head));
    assign k_back  = ((r_act == ACT_APPEND) && !c_empty) ||
                     ((r_act == ACT_AFTER) && (r_cur == r_tail));
    assign k_midb  = (r_act == ACT_BEFORE) && (r_cur != r_head);
    assign k_mida  = (r_act == ACT_AFTER) && (r_cur != r_tail);
    assign c_s     = {1'b0, r_slot};
    assign c_x     = (r_act == ACT_DELFRONT) ? r_head :
                     (r_act == ACT_DELBACK)  ? r_tail : r_cur;

    // Read addresses: links at acceptance, element once the links are known.
    logic [LW-1:0] c_lsel, c_tgt;
    always_comb begin
        case (i_s_axis_tuser)
            ACT_DELFRONT: c_lsel = r_head;
            ACT_DELBACK:  c_lsel = r_tail;
            default:      c_lsel = r_cur;
        endcase
        case (r_act)
            ACT_PREV: c_tgt = pv_rd;
            ACT_NEXT: c_tgt = nx_rd;
            ACT_DELFRONT, ACT_DELBACK, ACT_DELCURSOR: c_tgt = (pv_rd == NIL) ? nx_rd : pv_rd;
            default:  c_tgt = NIL;
        endcase
    end
    assign lk_ra = f_sl(c_lsel);
    assign sk_ra = f_sl(r_fsd - ONE);
    assign el_ra = f_sl(c_tgt);

    // Memory writes: the new slot in S_EXEC, neighbors and free stack at commit.
    always_comb begin
        el_we = (r_state == S_EXEC) && c_ok && is_ins;
        el_wa = r_slot;
        nx_we = 1'b0; nx_wa = r_slot; nx_wd = NIL;
        pv_we = 1'b0; pv_wa = r_slot; pv_wd = NIL;
        sk_we = c_go && c_ok && is_del && (r_fsd < NIL);
        sk_wa = f_sl(r_fsd);
        sk_wd = f_sl(c_x);
        if (el_we) begin
            nx_we = 1'b1;
            pv_we = 1'b1;
            if (k_front) nx_wd = r_head;
            else if (k_midb) nx_wd = r_cur;
            else if (k_mida) nx_wd = r_nx;
            if (k_back) pv_wd = r_tail;
            else if (k_midb) pv_wd = r_pv;
            else if (k_mida) pv_wd = r_cur;
        end else if (c_go && c_ok) begin
            if (is_ins) begin
                nx_wd = c_s;
                pv_wd = c_s;
                if (k_back) begin nx_we = 1'b1; nx_wa = f_sl(r_tail); end
                if (k_midb) begin nx_we = 1'b1; nx_wa = f_sl(r_pv); end
                if (k_mida) begin nx_we = 1'b1; nx_wa = f_sl(r_cur); end
                if (k_front) begin pv_we = 1'b1; pv_wa = f_sl(r_head); end
                if (k_midb) begin pv_we = 1'b1; pv_wa = f_sl(r_cur); end
                if (k_mida) begin pv_we = 1'b1; pv_wa = f_sl(r_nx); end
            end else if (is_del) begin
                nx_we = (r_pv != NIL); nx_wa = f_sl(r_pv); nx_wd = r_nx;
                pv_we = (r_nx != NIL); pv_wa = f_sl(r_nx); pv_wd = r_pv;
            end
        end
    end

    // Next list registers for a successful action.
    always_comb begin
        n_head = r_head; n_tail = r_tail; n_cur = r_cur; n_cidx = r_cidx;
        n_count = r_count; n_fsd = r_fsd; n_fresh = r_fresh;
        n_hval = r_hval; n_tval = r_tval; n_cval = r_cval;
        if (c_ok) begin
            case (r_act)
                ACT_CLEAR: begin
                    n_head = NIL; n_tail = NIL; n_cur = NIL; n_cidx = '1;
                    n_count = '0; n_fsd = '0; n_fresh = '0;
                    n_hval = '0; n_tval = '0; n_cval = '0;
                end
                ACT_FRONT: begin
                    n_cur = r_head; n_cidx = '0; n_cval = r_hval;
                end
                ACT_BACK: begin
                    n_cur = r_tail; n_cidx = r_count - ONE; n_cval = r_tval;
                end
                ACT_PREV, ACT_NEXT: begin
                    n_cur  = r_tgt;
                    n_cval = r_eval;
                    if (r_tgt == NIL) n_cidx = '1;
                    else if (r_act == ACT_PREV) n_cidx = r_cidx - ONE;
                    else n_cidx = r_cidx + ONE;
                end
                ACT_PREPEND, ACT_APPEND, ACT_BEFORE, ACT_AFTER: begin
                    n_count = r_count + ONE;
                    if (r_fsd != '0) n_fsd = r_fsd - ONE;
                    else n_fresh = r_fresh + ONE;
                    if (k_first || k_front) begin n_head = c_s; n_hval = r_val; end
                    if (k_first || k_back) begin n_tail = c_s; n_tval = r_val; end
                    if ((k_front || k_midb) && c_cdef) n_cidx = r_cidx + ONE;
                end
                ACT_DELFRONT, ACT_DELBACK, ACT_DELCURSOR: begin
                    n_count = r_count - ONE;
                    if (r_fsd < NIL) n_fsd = r_fsd + ONE;
                    if (r_pv == NIL) begin
                        n_head = r_nx;
                        n_hval = (r_nx == NIL) ? '0 : r_eval;
                    end
                    if (r_nx == NIL) begin
                        n_tail = r_pv;
                        n_tval = (r_pv == NIL) ? '0 : r_eval;
                    end
                    if (c_x == r_cur) begin
                        n_cur = NIL; n_cidx = '1; n_cval = '0;
                    end else if ((c_x == r_head) && c_cdef) begin
                        n_cidx = r_cidx - ONE;
                    end
                end
                default: ;
            endcase
        end
    end

    // Sequencer and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE:   if (i_s_axis_tvalid) r_state <= S_LINK;
                S_LINK:   r_state <= S_EXEC;
                S_EXEC:   r_state <= S_COMMIT;
                S_COMMIT: if (c_go) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
        if (r_state == S_IDLE) begin
            r_act <= i_s_axis_tuser;
            r_val <= DATA_BITS'(i_s_axis_tdata);
        end
        if (r_state == S_LINK) begin
            r_nx   <= nx_rd;
            r_pv   <= pv_rd;
            r_tgt  <= c_tgt;
            r_slot <= (r_fsd != '0) ? sk_rd : f_sl(r_fresh);
        end
        if (r_state == S_EXEC) begin
            r_eval <= (r_tgt == NIL) ? '0 : el_rd;
        end
    end

    // List registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= NIL; r_tail <= NIL; r_cur <= NIL; r_cidx <= '1;
            r_count <= '0; r_fsd <= '0; r_fresh <= '0;
            r_hval <= '0; r_tval <= '0; r_cval <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (c_go) begin
                r_head <= n_head; r_tail <= n_tail; r_cur <= n_cur; r_cidx <= n_cidx;
                r_count <= n_count; r_fsd <= n_fsd; r_fresh <= n_fresh;
                r_hval <= n_hval; r_tval <= n_tval; r_cval <= n_cval;
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
        if (c_go) begin
            r_odata <= {3'b000,
                        VALUE_W'($signed(n_cval)),
                        VALUE_W'($signed(n_tval)),
                        VALUE_W'($signed(n_hval)),
                        (n_cur != NIL),
                        COUNT_W'($signed(n_cidx)),
                        COUNT_W'(n_count),
                        c_st};
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    // Consistency checks on the list registers.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NIL) else $error("element count above capacity");
    a_cursor_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur == NIL) == (r_cidx == '1)) else $error("cursor slot and index disagree");
    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == NIL && r_tail == NIL && r_cur == NIL))
        else $error("empty list with live ends");
    a_commit_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT && r_ovalid && !i_m_axis_tready) |=> (r_state == S_COMMIT))
        else $error("commit passed a pending result");

endmodule
